// File: hdl/cfa_pkg.sv
package cfa_pkg;

    // sizing of the cell row
    localparam int NUM_CELLS = 64;
    localparam int CELL_W    = $clog2(NUM_CELLS);
    localparam int CNT_W     = $clog2(NUM_CELLS + 1);

    // fixed field widths
    localparam int FUNC_W     = 1;
    localparam int PID_W      = 8;
    localparam int SIZE_W     = 7;
    localparam int START_W    = 6;
    localparam int POLICY_W   = 2;
    localparam int CIU_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    // common width for comparing run lengths with request sizes
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    // operation codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    // placement policies (code 3 behaves as first fit)
    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_IN_USE = 1'd1;

    localparam logic [CIU_W-1:0] CIU_RESET = 7'd64;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PID_W-1:0]  process_id;
        logic [SIZE_W-1:0] request_size;
    } t_req;

    typedef struct packed {
        logic               success;
        logic [START_W-1:0] start_index;
    } t_rsp;

    // configuration as seen by the sequencer
    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [CNT_W-1:0]    count;
    } t_cfg;

    // one memory entry
    typedef struct packed {
        logic             used;
        logic [PID_W-1:0] owner;
    } t_cell;

    // sequencer to cell memory
    typedef struct packed {
        logic              rd_en;
        logic [CELL_W-1:0] rd_addr;
        logic              wr_en;
        logic [CELL_W-1:0] wr_addr;
        t_cell             wr_data;
    } t_ram_req;

    // cell index masked to the start field width
    function automatic logic [START_W-1:0] to_start(input logic [CELL_W-1:0] idx);
        logic [CELL_W+START_W-1:0] wide;
        wide = {{START_W{1'b0}}, idx};
        return wide[START_W-1:0];
    endfunction

endpackage

// File: hdl/cfa_req_if.sv
interface cfa_req_if;
    import cfa_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/cfa_rsp_if.sv
interface cfa_rsp_if;
    import cfa_pkg::*;

    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/cfa_cell_ram.sv
module cfa_cell_ram (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cfa_pkg::t_ram_req i_ram,
    output cfa_pkg::t_cell    o_rd_data
);
    import cfa_pkg::*;

    t_cell                mem [NUM_CELLS];
    logic [NUM_CELLS-1:0] r_written;
    t_cell                r_rd_data;
    logic                 r_rd_written;

    // storage array, one write and one read port
    always_ff @(posedge i_clk) begin
        if (i_ram.wr_en) begin
            mem[i_ram.wr_addr] <= i_ram.wr_data;
        end
        if (i_ram.rd_en) begin
            r_rd_data    <= mem[i_ram.rd_addr];
            r_rd_written <= r_written[i_ram.rd_addr];
        end
    end

    // per-entry written flags, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_ram.wr_en) begin
            r_written[i_ram.wr_addr] <= 1'b1;
        end
    end

    // an entry never written reads as a free cell of owner zero
    assign o_rd_data.used  = r_rd_written & r_rd_data.used;
    assign o_rd_data.owner = r_rd_written ? r_rd_data.owner : '0;

endmodule

// File: hdl/cfa_ctrl.sv
module cfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cfa_req_if.sink           i_req,
    cfa_rsp_if.source         o_rsp,
    input  cfa_pkg::t_cfg     i_cfg,
    output cfa_pkg::t_ram_req o_ram,
    input  cfa_pkg::t_cell    i_ram
);
    import cfa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [FUNC_W-1:0]   r_func, n_func;
    logic [PID_W-1:0]    r_pid, n_pid;
    logic [SIZE_W-1:0]   r_size, n_size;
    logic [POLICY_W-1:0] r_policy, n_policy;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_raddr, n_raddr;
    logic                r_pend, n_pend;
    logic [CELL_W-1:0]   r_pidx, n_pidx;
    logic                r_found, n_found;
    logic [CELL_W-1:0]   r_pick_start, n_pick_start;
    logic [CNT_W-1:0]    r_pick_len, n_pick_len;
    logic [CELL_W-1:0]   r_run_start, n_run_start;
    logic [CNT_W-1:0]    r_run_len, n_run_len;
    logic [CELL_W-1:0]   r_waddr, n_waddr;
    logic [SIZE_W-1:0]   r_wleft, n_wleft;
    logic                r_res_succ, n_res_succ;
    logic [START_W-1:0]  r_res_start, n_res_start;
    logic                r_o_vld, n_o_vld;
    t_rsp                r_o_data, n_o_data;

    logic rd_issue;
    logic cell_free;
    logic cell_busy;
    logic scan_end;
    logic run_close;
    logic run_fits;
    logic run_better;
    logic run_take;
    logic final_found;
    logic [CELL_W-1:0] final_start;

    // scan bookkeeping
    assign rd_issue  = (r_raddr < r_count);
    assign cell_free = r_pend && !i_ram.used;
    assign cell_busy = r_pend && i_ram.used;
    assign scan_end  = !r_pend && !rd_issue;

    // run closes at a used cell or at the end of the active row
    assign run_close  = cell_busy || scan_end;
    assign run_fits   = (r_run_len != '0) && (CMP_W'(r_run_len) >= CMP_W'(r_size));
    assign run_better = !r_found
                      || ((r_policy == POL_BEST) && (r_run_len < r_pick_len))
                      || ((r_policy == POL_WORST) && (r_run_len > r_pick_len));
    assign run_take   = run_close && run_fits && run_better;

    assign final_found = r_found || run_take;
    assign final_start = run_take ? r_run_start : r_pick_start;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_o_vld;
    assign o_rsp.data  = r_o_data;

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_func       = r_func;
        n_pid        = r_pid;
        n_size       = r_size;
        n_policy     = r_policy;
        n_count      = r_count;
        n_raddr      = r_raddr;
        n_pend       = r_pend;
        n_pidx       = r_pidx;
        n_found      = r_found;
        n_pick_start = r_pick_start;
        n_pick_len   = r_pick_len;
        n_run_start  = r_run_start;
        n_run_len    = r_run_len;
        n_waddr      = r_waddr;
        n_wleft      = r_wleft;
        n_res_succ   = r_res_succ;
        n_res_start  = r_res_start;
        n_o_vld      = r_o_vld && !o_rsp.ready;
        n_o_data     = r_o_data;

        o_ram.rd_en   = 1'b0;
        o_ram.rd_addr = r_raddr[CELL_W-1:0];
        o_ram.wr_en   = 1'b0;
        o_ram.wr_addr = r_pidx;
        o_ram.wr_data = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_func       = i_req.data.func;
                    n_pid        = i_req.data.process_id;
                    n_size       = i_req.data.request_size;
                    n_policy     = i_cfg.policy;
                    n_count      = i_cfg.count;
                    n_raddr      = '0;
                    n_pend       = 1'b0;
                    n_found      = 1'b0;
                    n_pick_start = '0;
                    n_pick_len   = '0;
                    n_run_start  = '0;
                    n_run_len    = '0;
                    n_state      = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue one read a cycle, data comes back in the next cycle
                o_ram.rd_en = rd_issue;
                if (rd_issue) begin
                    n_raddr = r_raddr + CNT_W'(1);
                end
                n_pend = rd_issue;
                n_pidx = r_raddr[CELL_W-1:0];

                if (r_func == FUNC_FREE) begin
                    // release cells of this owner as they stream by
                    if (cell_busy && (i_ram.owner == r_pid)) begin
                        o_ram.wr_en   = 1'b1;
                        o_ram.wr_addr = r_pidx;
                        o_ram.wr_data = '0;
                    end
                    if (scan_end) begin
                        n_res_succ  = 1'b1;
                        n_res_start = '0;
                        n_state     = S_DONE;
                    end
                end else begin
                    // run tracking and pick update
                    if (run_take) begin
                        n_found      = 1'b1;
                        n_pick_start = r_run_start;
                        n_pick_len   = r_run_len;
                    end
                    if (cell_free) begin
                        if (r_run_len == '0) begin
                            n_run_start = r_pidx;
                        end
                        n_run_len = r_run_len + CNT_W'(1);
                    end
                    if (run_close) begin
                        n_run_len = '0;
                    end
                    if (scan_end) begin
                        if (!final_found) begin
                            n_res_succ  = 1'b0;
                            n_res_start = '0;
                            n_state     = S_DONE;
                        end else begin
                            n_res_succ  = 1'b1;
                            n_res_start = to_start(final_start);
                            n_waddr     = final_start;
                            n_wleft     = r_size;
                            n_state     = (r_size == '0) ? S_DONE : S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                // claim the chosen cells one a cycle
                o_ram.wr_en         = 1'b1;
                o_ram.wr_addr       = r_waddr;
                o_ram.wr_data.used  = 1'b1;
                o_ram.wr_data.owner = r_pid;
                n_waddr             = r_waddr + CELL_W'(1);
                n_wleft             = r_wleft - SIZE_W'(1);
                if (r_wleft == SIZE_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the result to the output register once it is free
                if (!r_o_vld || o_rsp.ready) begin
                    n_o_vld              = 1'b1;
                    n_o_data.success     = r_res_succ;
                    n_o_data.start_index = r_res_start;
                    n_state              = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_o_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_o_vld <= n_o_vld;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_func       <= n_func;
        r_pid        <= n_pid;
        r_size       <= n_size;
        r_policy     <= n_policy;
        r_count      <= n_count;
        r_raddr      <= n_raddr;
        r_pend       <= n_pend;
        r_pidx       <= n_pidx;
        r_found      <= n_found;
        r_pick_start <= n_pick_start;
        r_pick_len   <= n_pick_len;
        r_run_start  <= n_run_start;
        r_run_len    <= n_run_len;
        r_waddr      <= n_waddr;
        r_wleft      <= n_wleft;
        r_res_succ   <= n_res_succ;
        r_res_start  <= n_res_start;
        r_o_data     <= n_o_data;
    end

endmodule

// File: hdl/contiguous_fit_allocator.sv
// Contiguous fit allocator: a row of cells kept in a single-port-read,
// single-port-write memory, each cell free or owned by an 8-bit id, all
// free after reset. An allocate item streams the active cells out of the
// memory one per cycle to find free runs, picks one by the fit policy
// (first, best or worst fit, ties to the lowest start), then writes the
// owner into the requested cells one per cycle; a free item streams the
// same cells and clears those of the given owner as they pass. One item
// is worked on at a time: after accept the active cells (cells_in_use
// limited to the depth) are streamed, an allocate that places cells
// then writes them, and the result is handed on before the block
// returns to idle and takes the next item. The result sits in an output
// register, so the next item is taken while it waits. Configuration is
// written through the plain write port while idle; the user must keep
// to this, as the block itself does not enforce it.
module contiguous_fit_allocator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    cfa_req_if.sink                            i_req,
    cfa_rsp_if.source                          o_rsp,
    input  logic                               i_cfg_we,
    input  logic [cfa_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import cfa_pkg::*;

    logic [POLICY_W-1:0] r_fit_policy;
    logic [CIU_W-1:0]    r_cells_in_use;
    t_cfg                cfg;
    t_ram_req            ram_req;
    t_cell               ram_rd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_policy   <= POL_FIRST;
            r_cells_in_use <= CIU_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FIT_POLICY:   r_fit_policy   <= i_cfg_data[POLICY_W-1:0];
                CFG_CELLS_IN_USE: r_cells_in_use <= i_cfg_data[CIU_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // active cell count limited to the built depth
    always_comb begin
        cfg.policy = r_fit_policy;
        if (32'(r_cells_in_use) >= NUM_CELLS) begin
            cfg.count = CNT_W'(NUM_CELLS);
        end else begin
            cfg.count = CNT_W'(r_cells_in_use);
        end
    end

    cfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cfg   (cfg),
        .o_ram   (ram_req),
        .i_ram   (ram_rd)
    );

    cfa_cell_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ram     (ram_req),
        .o_rd_data (ram_rd)
    );

endmodule

// File: hdl/cfa_checker.sv
module cfa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic                          i_rsp_success,
    input logic [cfa_pkg::START_W-1:0]   i_rsp_start_index
);
    import cfa_pkg::*;

    // no result is shown right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_success)
            && $stable(i_rsp_start_index))
        else $error("stalled result changed");

    // a failed allocate reports start zero
    a_fail_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_success |-> i_rsp_start_index == '0)
        else $error("failed result with nonzero start");

    // one item at a time: ready drops after an accepted item
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("item accepted while another is in work");

    // a result needs at least the memory read turnaround
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !$rose(i_rsp_valid))
        else $error("result appeared one cycle after accept");

endmodule

bind contiguous_fit_allocator cfa_checker u_cfa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_success     (o_rsp.data.success),
    .i_rsp_start_index (o_rsp.data.start_index)
);

// File: sim/tb_contiguous_fit_allocator.sv
`timescale 1ns / 100ps

module tb_contiguous_fit_allocator;
    import cfa_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 200;
    localparam int LONG_HOLD     = 1500;
    localparam int CYCLE_LIMIT   = 3000000;
    localparam int REPORT_MAX    = 10;
    localparam int POOL_SIZE     = 8;
    localparam int NUM_PHASES    = 12;
    localparam int PHASE_ITEMS   = 160;
    localparam int PRESSURE_AT   = 40;

    // policy code with no rule of its own, placed like first fit
    localparam logic [POLICY_W-1:0] POL_SPARE = 2'd3;

    // settings for the random phases
    localparam logic [POLICY_W-1:0] PHASE_POLICY [NUM_PHASES] = '{
        POL_FIRST, POL_BEST, POL_WORST, POL_SPARE, POL_BEST, POL_WORST,
        POL_FIRST, POL_BEST, POL_WORST, POL_FIRST, POL_BEST, POL_WORST};
    localparam logic [CIU_W-1:0] PHASE_CELLS [NUM_PHASES] = '{
        7'd64, 7'd64, 7'd64, 7'd64, 7'd17, 7'd100,
        7'd2, 7'd1, 7'd0, 7'd127, 7'd64, 7'd64};
    localparam bit PHASE_REQ_IDLE  [NUM_PHASES] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1};
    localparam bit PHASE_RSP_STALL [NUM_PHASES] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0};
    localparam int PRESSURE_PHASE = 2;

    // cell row tracker and expected result store
    class alloc_scoreboard;
        logic [PID_W-1:0]    owner_of [NUM_CELLS];
        bit                  taken    [NUM_CELLS];
        logic [POLICY_W-1:0] policy;
        logic [CIU_W-1:0]    cell_total;
        t_rsp                expected_placements [$];
        int unsigned         mismatches, strays, reported, checked;
        int unsigned         placed, refused, releases;

        function new();
            foreach (taken[i]) begin
                taken[i]    = 1'b0;
                owner_of[i] = '0;
            end
            policy     = POL_FIRST;
            cell_total = CIU_RESET;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == CFG_FIT_POLICY) begin
                policy = value[POLICY_W-1:0];
            end else begin
                cell_total = value[CIU_W-1:0];
            end
        endfunction

        // apply one request to the tracked row and return its outcome
        function t_rsp place_or_release(t_req item);
            t_rsp        res;
            int unsigned active, i, run_start, run_len, pick_start, pick_len;
            bit          found, take, is_free;
            res        = '0;
            active     = (cell_total < NUM_CELLS) ? cell_total : NUM_CELLS;
            found      = 1'b0;
            run_start  = 0;
            run_len    = 0;
            pick_start = 0;
            pick_len   = 0;
            if (item.func == FUNC_FREE) begin
                for (i = 0; i < active; i++) begin
                    if (taken[i] && owner_of[i] == item.process_id) begin
                        taken[i]    = 1'b0;
                        owner_of[i] = '0;
                    end
                end
                res.success = 1'b1;
                return res;
            end
            // walk the active cells, judging each free run as it closes
            for (i = 0; i <= active; i++) begin
                is_free = (i < active) && !taken[i];
                if (is_free) begin
                    if (run_len == 0) run_start = i;
                    run_len++;
                end else begin
                    if (run_len > 0 && run_len >= item.request_size) begin
                        if (!found) take = 1'b1;
                        else if (policy == POL_BEST) take = run_len < pick_len;
                        else if (policy == POL_WORST) take = run_len > pick_len;
                        else take = 1'b0;
                        if (take) begin
                            found      = 1'b1;
                            pick_start = run_start;
                            pick_len   = run_len;
                        end
                    end
                    run_len = 0;
                end
            end
            if (!found) return res;
            for (i = 0; i < item.request_size; i++) begin
                if (pick_start + i < active) begin
                    taken[pick_start + i]    = 1'b1;
                    owner_of[pick_start + i] = item.process_id;
                end
            end
            res.success     = 1'b1;
            res.start_index = START_W'(pick_start);
            return res;
        endfunction

        function void note_request(t_req item);
            t_rsp want;
            want = place_or_release(item);
            if (item.func == FUNC_FREE) releases++;
            else if (want.success) placed++;
            else refused++;
            expected_placements.push_back(want);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (expected_placements.size() == 0) begin
                strays++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("unexpected result: success=%0b start=%0d",
                             got.success, got.start_index);
                end
                return;
            end
            want = expected_placements.pop_front();
            if (got.success !== want.success || got.start_index !== want.start_index) begin
                mismatches++;
                if (reported < REPORT_MAX) begin
                    reported++;
                    $display("result %0d mismatch: expected success=%0b start=%0d, got success=%0b start=%0d",
                             checked, want.success, want.start_index,
                             got.success, got.start_index);
                end
            end
            checked++;
        endfunction

        function int unsigned pending();
            return expected_placements.size();
        endfunction

        function int unsigned failures();
            return mismatches + strays + expected_placements.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfa_req_if req_if();
    cfa_rsp_if rsp_if();

    alloc_scoreboard  sb;
    logic [PID_W-1:0] owner_pool [POOL_SIZE];
    bit               req_idle_on;
    bit               rsp_stall_on;
    bit               long_hold_pending;
    int unsigned      cycle_count = 0;

    contiguous_fit_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, sb.pending());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        else if (roll < 85) return $urandom_range(1, 4);
        else if (roll < 97) return $urandom_range(5, 20);
        else return $urandom_range(40, 150);
    endfunction

    // result ready, with random stalls and one long hold-off
    initial begin : rsp_ready_gen
        int unsigned stall;
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            stall = idle_length();
            if (long_hold_pending) begin
                long_hold_pending = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (rsp_stall_on && stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) sb.check_response(rsp_if.data);
    end

    task automatic send_request(input logic [FUNC_W-1:0] func,
                                input logic [PID_W-1:0] pid,
                                input logic [SIZE_W-1:0] size);
        t_req        item;
        int unsigned gap;
        item.func         = func;
        item.process_id   = pid;
        item.request_size = size;
        gap = req_idle_on ? idle_length() : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(item);
    endtask

    // stop offering and let every outstanding result come back
    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        sb.set_config(idx, value);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reconfigure(input logic [POLICY_W-1:0] pol, input logic [CIU_W-1:0] cnt);
        drain_results();
        write_register(CFG_FIT_POLICY, CFG_DATA_W'(pol));
        write_register(CFG_CELLS_IN_USE, CFG_DATA_W'(cnt));
    endtask

    function automatic logic [SIZE_W-1:0] pick_size();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return SIZE_W'($urandom_range(1, 6));
        else if (roll < 95) return SIZE_W'($urandom_range(1, 16));
        else return SIZE_W'($urandom_range(17, 40));
    endfunction

    // mostly allocates and frees over a small owner set
    task automatic send_random_request();
        int unsigned      roll;
        logic [PID_W-1:0] pid;
        roll = $urandom_range(0, 99);
        pid  = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 55) send_request(FUNC_ALLOC, pid, pick_size());
        else if (roll < 83) send_request(FUNC_FREE, pid, SIZE_W'($urandom_range(0, 127)));
        else if (roll < 88) send_request(FUNC_ALLOC, pid, '0);
        else if (roll < 94) send_request(FUNC_ALLOC, pid, SIZE_W'($urandom_range(41, 64)));
        else if (roll < 97) send_request(FUNC_FREE, PID_W'($urandom_range(0, 255)),
                                         SIZE_W'($urandom_range(0, 127)));
        else send_request(FUNC_ALLOC, pid, SIZE_W'($urandom_range(65, 127)));
    endtask

    initial begin : stimulus
        int unsigned ph, n;
        sb                = new();
        i_rst_n           = 1'b0;
        req_if.valid      = 1'b0;
        req_if.data       = '0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_FIT_POLICY;
        cfg_data          = '0;
        req_idle_on       = 1'b0;
        rsp_stall_on      = 1'b0;
        long_hold_pending = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty and full row, zero size, oversized, unknown owner
        send_request(FUNC_ALLOC, 8'h00, 7'd0);
        send_request(FUNC_ALLOC, 8'hFF, 7'd64);
        send_request(FUNC_ALLOC, 8'h01, 7'd1);
        send_request(FUNC_ALLOC, 8'h01, 7'd0);
        send_request(FUNC_FREE, 8'h5A, 7'd0);
        send_request(FUNC_FREE, 8'hFF, 7'd0);
        send_request(FUNC_ALLOC, 8'h80, 7'd127);
        send_request(FUNC_ALLOC, 8'h80, 7'd65);

        // holes of 10, 20 and 24 cells
        send_request(FUNC_ALLOC, 8'h01, 7'd5);
        send_request(FUNC_ALLOC, 8'h02, 7'd10);
        send_request(FUNC_ALLOC, 8'h03, 7'd3);
        send_request(FUNC_ALLOC, 8'h04, 7'd20);
        send_request(FUNC_ALLOC, 8'h05, 7'd2);
        send_request(FUNC_FREE, 8'h02, 7'd0);
        send_request(FUNC_FREE, 8'h04, 7'd0);
        send_request(FUNC_ALLOC, 8'h06, 7'd3);

        // each policy on the same holes
        reconfigure(POL_BEST, 7'd64);
        send_request(FUNC_ALLOC, 8'h07, 7'd6);
        reconfigure(POL_WORST, 7'd64);
        send_request(FUNC_ALLOC, 8'h08, 7'd4);
        send_request(FUNC_ALLOC, 8'h09, 7'd0);
        reconfigure(POL_SPARE, 7'd64);
        send_request(FUNC_ALLOC, 8'h0A, 7'd2);

        // no active cells, count past the depth, single cell
        reconfigure(POL_FIRST, 7'd0);
        send_request(FUNC_ALLOC, 8'h11, 7'd0);
        send_request(FUNC_FREE, 8'h01, 7'd0);
        reconfigure(POL_WORST, 7'd127);
        send_request(FUNC_ALLOC, 8'hC3, 7'd30);
        reconfigure(POL_FIRST, 7'd1);
        send_request(FUNC_FREE, 8'h01, 7'd0);
        send_request(FUNC_ALLOC, 8'h3C, 7'd1);

        // random phases over the settings table
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            reconfigure(PHASE_POLICY[ph], PHASE_CELLS[ph]);
            req_idle_on  = PHASE_REQ_IDLE[ph];
            rsp_stall_on = PHASE_RSP_STALL[ph];
            foreach (owner_pool[k]) owner_pool[k] = PID_W'($urandom_range(0, 255));
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == PRESSURE_PHASE && n == PRESSURE_AT) long_hold_pending = 1'b1;
                send_random_request();
            end
        end

        drain_results();
        repeat (END_CYCLES) @(posedge i_clk);
        $display("covered %0d allocates (%0d placed, %0d refused) and %0d frees, %0d results checked",
                 sb.placed + sb.refused, sb.placed, sb.refused, sb.releases, sb.checked);
        $display("over %0d policy and cell count settings, with a %0d-cycle result hold-off",
                 NUM_PHASES + 6, LONG_HOLD);
        if (sb.failures() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d unexpected results, %0d missing",
                     sb.mismatches, sb.strays, sb.pending());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
